### hdl/mppf_pkg.sv
// Package for the morphological point pair filter.
// Holds the sizing constants, register and opcode codes, pipeline types and
// the square root step; no dependencies.
package mppf_pkg;

    localparam int KERNEL_LEN = 64;
    localparam int KIDX_W     = (KERNEL_LEN > 1) ? $clog2(KERNEL_LEN) : 1;
    localparam int COORD_BITS = 32;
    localparam int SQRT_STEPS = 32;

    // Configuration register indexes.
    localparam logic [2:0] REG_REACH_LIMIT = 3'd0;
    localparam logic [2:0] REG_PIXEL_SIZE  = 3'd1;
    localparam logic [2:0] REG_USE_STDEV   = 3'd2;
    localparam logic [2:0] REG_POINT_STDEV = 3'd3;
    localparam logic [2:0] REG_TOLERANCE   = 3'd4;

    // Item opcodes.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // Sideband that travels with every item down the pipeline.
    typedef struct packed {
        logic                     vld;
        logic                     op;
        logic                     rng;
        logic signed [COORD_BITS:0] hd;
        logic [5:0]               widx;
        logic [31:0]              wh;
        logic [30:0]              ws;
        logic [KIDX_W-1:0]        idx;
    } side_t;

    // Working state of one bit-pair step of the integer square root.
    typedef struct packed {
        logic [63:0] n;
        logic [63:0] r;
    } sqrt_t;

    // One step of the digit-by-digit square root; step k tests bit 62 - 2k.
    function automatic sqrt_t isqrt_step(input sqrt_t s, input int k);
        logic [63:0] bitv;
        logic [63:0] t;
        sqrt_t       o;
        bitv = 64'd1 << (62 - 2 * k);
        t    = s.r + bitv;
        if (s.n >= t) begin
            o.n = s.n - t;
            o.r = (s.r >> 1) + bitv;
        end else begin
            o.n = s.n;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

endpackage

### hdl/morphological_point_pair_filter_top.sv
// Morphological point pair filter, top level.
// Depends on mppf_pkg for constants, types and the square root step.

// One item enters per clock cycle while the result side does not stall; the
// number of division stages comes from the kernel table length, and most
// of the pipeline depth is set by the two fully pipelined
// 32-step square roots, one for the pair distance and one for the combined
// standard deviation. Load items write the kernel table in the same pipeline
// slot where test items read it, so a test item always sees every load that
// was accepted before it. A stall on the result side holds the whole
// pipeline; input is taken in every cycle in which the output register is
// empty or being emptied. Configuration must only be written while the
// pipeline is empty.
module morphological_point_pair_filter_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write channel.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Input item channel.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_opcode,
    input  logic [5:0]  s_entry_index,
    input  logic signed [31:0] s_entry_height,
    input  logic [30:0] s_entry_stdev,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    input  logic signed [31:0] s_neighbour_x,
    input  logic signed [31:0] s_neighbour_y,
    input  logic signed [31:0] s_neighbour_z,
    // Result item channel.
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_in_range,
    output logic        m_flag_point,
    output logic        m_flag_neighbour
);
    import mppf_pkg::*;

    localparam int DW = 32 + KIDX_W;

    // Configuration registers.
    logic [30:0]        reach_limit_reg;
    logic [30:0]        pixel_size_reg;
    logic               use_stdev_reg;
    logic [30:0]        point_stdev_reg;
    logic signed [31:0] tolerance_reg;

    logic en;

    // Kernel table memories.
    logic [31:0] height_mem [KERNEL_LEN];
    logic [30:0] stdev_mem  [KERNEL_LEN];

    // Pipeline registers.
    side_t       a_side_reg, a_side_next;
    logic [31:0] a_dx_reg, a_dx_next, a_dy_reg, a_dy_next;
    side_t       b_side_reg, b_side_next;
    logic [61:0] b_sqx_reg, b_sqy_reg;
    side_t       c_side_reg;
    logic [62:0] c_sum_reg;
    side_t       sq1_side_reg [SQRT_STEPS];
    sqrt_t       sq1_reg      [SQRT_STEPS];
    sqrt_t       sq1_next     [SQRT_STEPS];
    side_t       d_side_reg, d_side_next;
    logic [31:0] d_rem_reg;
    logic        d_ovf_reg, d_ovf_next;
    side_t       dv_side_reg [KIDX_W];
    logic [31:0] dv_rem_reg  [KIDX_W];
    logic [31:0] dv_rem_next [KIDX_W];
    logic [KIDX_W-1:0] dv_q_reg  [KIDX_W];
    logic [KIDX_W-1:0] dv_q_next [KIDX_W];
    logic        dv_ovf_reg [KIDX_W];
    side_t       mr_side_reg, mr_side_next;
    logic [31:0] h_rd_reg;
    logic [30:0] s_rd_reg;
    side_t       p_side_reg, p_side_next;
    logic [61:0] p_ks2_reg, p_ps2_reg;
    side_t       q_side_reg;
    logic [62:0] q_sum_reg;
    side_t       sq2_side_reg [SQRT_STEPS];
    sqrt_t       sq2_reg      [SQRT_STEPS];
    sqrt_t       sq2_next     [SQRT_STEPS];
    side_t       t_side_reg;
    logic signed [35:0] t_margin_reg, t_margin_next;
    side_t       u_side_reg;
    logic signed [36:0] u_thr_reg, u_thr_next;
    logic        out_valid_reg;
    logic        out_op_reg;
    logic        out_rng_reg, out_rng_next;
    logic        out_fp_reg, out_fp_next;
    logic        out_fn_reg, out_fn_next;

    logic [30:0] pix;

    // The whole pipeline moves unless a finished item is held at the output.
    assign en        = !out_valid_reg || m_ready;
    assign s_ready   = en;
    assign cfg_ready = 1'b1;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reach_limit_reg <= '0;
            pixel_size_reg  <= 31'd1000;
            use_stdev_reg   <= 1'b0;
            point_stdev_reg <= '0;
            tolerance_reg   <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_REACH_LIMIT: reach_limit_reg <= cfg_data[30:0];
                REG_PIXEL_SIZE:  pixel_size_reg  <= cfg_data[30:0];
                REG_USE_STDEV:   use_stdev_reg   <= cfg_data[0];
                REG_POINT_STDEV: point_stdev_reg <= cfg_data[30:0];
                REG_TOLERANCE:   tolerance_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Stage A: absolute coordinate offsets and the height difference.
    always_comb begin
        logic signed [COORD_BITS:0] ddx, ddy;
        ddx = $signed({s_point_x[COORD_BITS-1], s_point_x[COORD_BITS-1:0]})
            - $signed({s_neighbour_x[COORD_BITS-1], s_neighbour_x[COORD_BITS-1:0]});
        ddy = $signed({s_point_y[COORD_BITS-1], s_point_y[COORD_BITS-1:0]})
            - $signed({s_neighbour_y[COORD_BITS-1], s_neighbour_y[COORD_BITS-1:0]});
        a_dx_next = 32'(ddx[COORD_BITS] ? -ddx : ddx);
        a_dy_next = 32'(ddy[COORD_BITS] ? -ddy : ddy);
        a_side_next.vld  = s_valid;
        a_side_next.op   = s_opcode;
        a_side_next.rng  = (s_opcode == OP_TEST);
        a_side_next.hd   = $signed({s_point_z[COORD_BITS-1], s_point_z[COORD_BITS-1:0]})
                         - $signed({s_neighbour_z[COORD_BITS-1], s_neighbour_z[COORD_BITS-1:0]});
        a_side_next.widx = s_entry_index;
        a_side_next.wh   = s_entry_height;
        a_side_next.ws   = s_entry_stdev;
        a_side_next.idx  = '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_side_reg <= '0;
        end else if (en) begin
            a_side_reg <= a_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_dx_reg <= a_dx_next;
            a_dy_reg <= a_dy_next;
        end
    end

    // Stage B: early range test on each offset and the two squares.
    always_comb begin
        b_side_next     = a_side_reg;
        b_side_next.rng = a_side_reg.rng && (a_dx_reg <= {1'b0, reach_limit_reg})
                          && (a_dy_reg <= {1'b0, reach_limit_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_side_reg <= '0;
        end else if (en) begin
            b_side_reg <= b_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b_sqx_reg <= a_dx_reg[30:0] * a_dx_reg[30:0];
            b_sqy_reg <= a_dy_reg[30:0] * a_dy_reg[30:0];
        end
    end

    // Stage C: sum of squares.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_side_reg <= '0;
        end else if (en) begin
            c_side_reg <= b_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_sum_reg <= 63'(b_sqx_reg) + 63'(b_sqy_reg);
        end
    end

    // Distance square root, one bit of the root per stage.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq1
        if (k == 0) begin : g_first
            assign sq1_next[k] = isqrt_step('{n: 64'(c_sum_reg), r: 64'd0}, k);
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    sq1_side_reg[k] <= '0;
                end else if (en) begin
                    sq1_side_reg[k] <= c_side_reg;
                end
            end
        end else begin : g_rest
            assign sq1_next[k] = isqrt_step(sq1_reg[k-1], k);
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    sq1_side_reg[k] <= '0;
                end else if (en) begin
                    sq1_side_reg[k] <= sq1_side_reg[k-1];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                sq1_reg[k] <= sq1_next[k];
            end
        end
    end

    // Stage D: final range test and the table overflow test of the division.
    assign pix = (pixel_size_reg == '0) ? 31'd1 : pixel_size_reg;

    always_comb begin
        logic [31:0] root_mm;
        root_mm           = sq1_reg[SQRT_STEPS-1].r[31:0];
        d_side_next       = sq1_side_reg[SQRT_STEPS-1];
        d_side_next.rng   = d_side_next.rng && (root_mm <= {1'b0, reach_limit_reg});
        d_ovf_next        = DW'(root_mm) >= {1'b0, pix, KIDX_W'(0)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_side_reg <= '0;
        end else if (en) begin
            d_side_reg <= d_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_rem_reg <= sq1_reg[SQRT_STEPS-1].r[31:0];
            d_ovf_reg <= d_ovf_next;
        end
    end

    // Restoring division of the distance by the pixel size, one quotient bit
    // per stage, most significant first.
    for (genvar j = 0; j < KIDX_W; j++) begin : g_div
        localparam int B = KIDX_W - 1 - j;
        logic [31:0]       rem_in;
        logic [KIDX_W-1:0] q_in;
        logic [DW-1:0]     dsh;
        if (j == 0) begin : g_first
            assign rem_in = d_rem_reg;
            assign q_in   = '0;
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dv_side_reg[j] <= '0;
                end else if (en) begin
                    dv_side_reg[j] <= d_side_reg;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    dv_ovf_reg[j] <= d_ovf_reg;
                end
            end
        end else begin : g_rest
            assign rem_in = dv_rem_reg[j-1];
            assign q_in   = dv_q_reg[j-1];
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dv_side_reg[j] <= '0;
                end else if (en) begin
                    dv_side_reg[j] <= dv_side_reg[j-1];
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    dv_ovf_reg[j] <= dv_ovf_reg[j-1];
                end
            end
        end
        assign dsh = DW'(pix) << B;
        always_comb begin
            dv_rem_next[j] = rem_in;
            dv_q_next[j]   = q_in;
            if (DW'(rem_in) >= dsh) begin
                dv_rem_next[j]  = 32'(DW'(rem_in) - dsh);
                dv_q_next[j][B] = 1'b1;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                dv_rem_reg[j] <= dv_rem_next[j];
                dv_q_reg[j]   <= dv_q_next[j];
            end
        end
    end

    // Table index, clamped to the last entry.
    always_comb begin
        mr_side_next = dv_side_reg[KIDX_W-1];
        if (dv_ovf_reg[KIDX_W-1] || ({1'b0, dv_q_reg[KIDX_W-1]} >= (KIDX_W+1)'(KERNEL_LEN))) begin
            mr_side_next.idx = KIDX_W'(KERNEL_LEN - 1);
        end else begin
            mr_side_next.idx = dv_q_reg[KIDX_W-1];
        end
    end

    // Stage M: kernel table access. Loads write and tests read in the same
    // slot, so program order is kept without forwarding.
    always_ff @(posedge aclk) begin
        if (en && mr_side_next.vld && (mr_side_next.op == OP_LOAD)
                && ({1'b0, mr_side_next.widx} < 7'(KERNEL_LEN))) begin
            height_mem[KIDX_W'(mr_side_next.widx)] <= mr_side_next.wh;
            stdev_mem[KIDX_W'(mr_side_next.widx)]  <= mr_side_next.ws;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            h_rd_reg <= height_mem[mr_side_next.idx];
            s_rd_reg <= stdev_mem[mr_side_next.idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mr_side_reg <= '0;
        end else if (en) begin
            mr_side_reg <= mr_side_next;
        end
    end

    // Stage P: squares of the two deviations; the entry height rides along.
    always_comb begin
        p_side_next    = mr_side_reg;
        p_side_next.wh = h_rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_side_reg <= '0;
        end else if (en) begin
            p_side_reg <= p_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_ks2_reg <= s_rd_reg * s_rd_reg;
            p_ps2_reg <= point_stdev_reg * point_stdev_reg;
        end
    end

    // Stage Q: sum of the variances.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_side_reg <= '0;
        end else if (en) begin
            q_side_reg <= p_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q_sum_reg <= 63'(p_ks2_reg) + 63'(p_ps2_reg);
        end
    end

    // Deviation square root, same structure as the distance root.
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq2
        if (k == 0) begin : g_first
            assign sq2_next[k] = isqrt_step('{n: 64'(q_sum_reg), r: 64'd0}, k);
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    sq2_side_reg[k] <= '0;
                end else if (en) begin
                    sq2_side_reg[k] <= q_side_reg;
                end
            end
        end else begin : g_rest
            assign sq2_next[k] = isqrt_step(sq2_reg[k-1], k);
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    sq2_side_reg[k] <= '0;
                end else if (en) begin
                    sq2_side_reg[k] <= sq2_side_reg[k-1];
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                sq2_reg[k] <= sq2_next[k];
            end
        end
    end

    // Stage T: margin is the tolerance, plus three times the combined deviation when use_stdev is set.
    always_comb begin
        logic [31:0] sd;
        logic [33:0] three_sd;
        sd       = sq2_reg[SQRT_STEPS-1].r[31:0];
        three_sd = 34'({sd, 1'b0}) + 34'(sd);
        t_margin_next = 36'(tolerance_reg);
        if (use_stdev_reg) begin
            t_margin_next = t_margin_next + $signed({2'b00, three_sd});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t_side_reg <= '0;
        end else if (en) begin
            t_side_reg <= sq2_side_reg[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_margin_reg <= t_margin_next;
        end
    end

    // Stage U: threshold is the entry height plus the margin.
    assign u_thr_next = 37'($signed(t_side_reg.wh)) + 37'(t_margin_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_side_reg <= '0;
        end else if (en) begin
            u_side_reg <= t_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            u_thr_reg <= u_thr_next;
        end
    end

    // Output stage: compare the height difference both ways.
    always_comb begin
        logic signed [36:0] hd;
        logic               above;
        hd           = 37'(u_side_reg.hd);
        above        = hd > u_thr_reg;
        out_rng_next = u_side_reg.rng;
        out_fp_next  = u_side_reg.rng && above;
        out_fn_next  = u_side_reg.rng && !above && ((-hd) > u_thr_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= u_side_reg.vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_op_reg  <= u_side_reg.op;
            out_rng_reg <= out_rng_next;
            out_fp_reg  <= out_fp_next;
            out_fn_reg  <= out_fn_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_in_range       = out_rng_reg;
    assign m_flag_point     = out_fp_reg;
    assign m_flag_neighbour = out_fn_reg;

    // At most one of the pair is flagged.
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> !(out_fp_reg && out_fn_reg))
        else $error("both points of a pair flagged");

    // A flag is only raised for a pair within range.
    a_flag_needs_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_fp_reg || out_fn_reg)) |-> out_rng_reg)
        else $error("flag raised on an out of range pair");

    // A load item never reports a tested pair.
    a_load_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_op_reg == OP_LOAD)) |-> !out_rng_reg)
        else $error("load item reported as in range");

endmodule

### bench/morphological_point_pair_filter_top_test.sv
// Self-checking bench for the morphological point pair filter top level.
// Depends on mppf_pkg and morphological_point_pair_filter_top; it predicts
// every result in its own model and compares the results in order.

// Expected result of one item.
typedef struct packed {
    logic in_range;
    logic flag_point;
    logic flag_neighbour;
} pair_verdict_t;

// Holds the filter's expected verdicts and checks the verdicts that come out.
class verdict_board;
    pair_verdict_t pending[$];
    int            errors;
    int            checked;

    // Records the verdict that an accepted item should produce.
    function void note_item(pair_verdict_t v);
        pending.push_back(v);
    endfunction

    // Compares one result with the oldest pending verdict.
    function void check_verdict(pair_verdict_t got);
        pair_verdict_t want;
        if (pending.size() == 0) begin
            report("result arrived with nothing pending");
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got.in_range !== want.in_range)
            report($sformatf("in_range got %0b want %0b", got.in_range, want.in_range));
        if (got.flag_point !== want.flag_point)
            report($sformatf("flag_point got %0b want %0b", got.flag_point,
                             want.flag_point));
        if (got.flag_neighbour !== want.flag_neighbour)
            report($sformatf("flag_neighbour got %0b want %0b", got.flag_neighbour,
                             want.flag_neighbour));
    endfunction

    // Counts one mismatch and prints its line, for the first 40 only.
    function void report(string msg);
        errors++;
        if (errors <= 40)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction
endclass

module morphological_point_pair_filter_top_test;
    import mppf_pkg::*;

    localparam longint CYCLE_LIMIT = 400000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_opcode = OP_LOAD;
    logic [5:0]  s_entry_index = '0;
    logic signed [31:0] s_entry_height = '0;
    logic [30:0] s_entry_stdev = '0;
    logic signed [31:0] s_point_x = '0, s_point_y = '0, s_point_z = '0;
    logic signed [31:0] s_neighbour_x = '0, s_neighbour_y = '0, s_neighbour_z = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_in_range, m_flag_point, m_flag_neighbour;

    morphological_point_pair_filter_top dut (.*);

    always #4 aclk = ~aclk;

    // Predictor state: configuration and the kernel table.
    logic [30:0]        range_mm = 31'd0;
    logic [30:0]        pixel_mm = 31'd1000;
    logic               stdev_on = 1'b0;
    logic [30:0]        point_dev = 31'd0;
    logic signed [31:0] tol_mm = 32'sd0;
    logic signed [31:0] kern_height [KERNEL_LEN];
    logic [30:0]        kern_dev [KERNEL_LEN];

    verdict_board board = new();
    longint cycles = 0;
    bit     quiet_sink = 1'b0;
    bit     quiet_source = 1'b0;
    int     loads = 0, tests = 0, hits = 0;

    // Floored integer square root, bit pair by bit pair.
    function automatic logic [63:0] floor_root(logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Works out the verdict for one item and updates the kernel table on loads.
    function automatic pair_verdict_t predict_verdict(logic op, logic [5:0] ei,
            logic signed [31:0] eh, logic [30:0] es,
            logic signed [31:0] px, logic signed [31:0] py, logic signed [31:0] pz,
            logic signed [31:0] nx, logic signed [31:0] ny, logic signed [31:0] nz);
        pair_verdict_t v;
        longint dx, dy, hd, margin, thr;
        logic [63:0] span, idx, pix, sq;
        v = '0;
        if (op == OP_LOAD) begin
            kern_height[ei] = eh;
            kern_dev[ei] = es;
            return v;
        end
        dx = longint'(px) - longint'(nx);
        if (dx < 0) dx = -dx;
        dy = longint'(py) - longint'(ny);
        if (dy < 0) dy = -dy;
        if (dx > longint'(range_mm) || dy > longint'(range_mm)) return v;
        span = floor_root(64'(dx) * 64'(dx) + 64'(dy) * 64'(dy));
        if (span > 64'(range_mm)) return v;
        v.in_range = 1'b1;
        pix = (pixel_mm == 0) ? 64'd1 : 64'(pixel_mm);
        idx = span / pix;
        if (idx >= KERNEL_LEN) idx = KERNEL_LEN - 1;
        margin = longint'(tol_mm);
        if (stdev_on) begin
            sq = floor_root(64'(kern_dev[idx]) * 64'(kern_dev[idx])
                            + 64'(point_dev) * 64'(point_dev));
            margin = margin + 3 * longint'(sq);
        end
        thr = longint'(kern_height[idx]) + margin;
        hd = longint'(pz) - longint'(nz);
        if (hd > thr) v.flag_point = 1'b1;
        else if (-hd > thr) v.flag_neighbour = 1'b1;
        return v;
    endfunction

    // Takes a break with a chance of 14 in a hundred unless a quiet stretch is on.
    function automatic bit take_break(bit quiet);
        return !quiet && ($urandom_range(99) < 14);
    endfunction

    // Result side: random back-pressure and checking.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_valid && m_ready)
                board.check_verdict({m_in_range, m_flag_point, m_flag_neighbour});
            m_ready <= !take_break(quiet_sink);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("morphological_point_pair_filter_top_test failed");
            $finish;
        end
    end

    // Writes one configuration register and mirrors it in the predictor.
    // Valid stays up after the write; the next item send lowers it.
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_REACH_LIMIT: range_mm = val[30:0];
            REG_PIXEL_SIZE:  pixel_mm = val[30:0];
            REG_USE_STDEV:   stdev_on = val[0];
            REG_POINT_STDEV: point_dev = val[30:0];
            REG_TOLERANCE:   tol_mm = val;
            default: ;
        endcase
    endtask

    // Sends one item, possibly after a random gap, and records its verdict.
    task automatic send_item(logic op, logic [5:0] ei, logic signed [31:0] eh,
            logic [30:0] es, logic signed [31:0] px, logic signed [31:0] py,
            logic signed [31:0] pz, logic signed [31:0] nx, logic signed [31:0] ny,
            logic signed [31:0] nz);
        cfg_valid <= 1'b0;
        while (take_break(quiet_source)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_entry_index <= ei;
        s_entry_height <= eh;
        s_entry_stdev <= es;
        s_point_x <= px;
        s_point_y <= py;
        s_point_z <= pz;
        s_neighbour_x <= nx;
        s_neighbour_y <= ny;
        s_neighbour_z <= nz;
        do @(posedge aclk); while (!s_ready);
        board.note_item(predict_verdict(op, ei, eh, es, px, py, pz, nx, ny, nz));
        if (op == OP_LOAD) loads++;
        else tests++;
        if (board.pending[$].in_range) hits++;
    endtask

    task automatic load_entry(logic [5:0] ei, logic signed [31:0] eh, logic [30:0] es);
        send_item(OP_LOAD, ei, eh, es, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
    endtask

    // A test pair with offsets mostly within a given reach; junk load fields.
    task automatic test_pair(int reach);
        logic signed [31:0] px, py, pz;
        px = $urandom;
        py = $urandom;
        pz = $urandom_range(20000) - 10000;
        send_item(OP_TEST, 6'($urandom), $urandom, 31'($urandom), px, py, pz,
                  px + $signed($urandom_range(2 * reach) - reach),
                  py + $signed($urandom_range(2 * reach) - reach),
                  pz + $signed($urandom_range(4000) - 2000));
    endtask

    // Waits until nothing is pending, then lets the pipeline drain.
    task automatic drain();
        longint start;
        s_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        start = cycles;
        while (cycles < start + 120) @(posedge aclk);
    endtask

    // Every entry filled with random content so no unwritten read can occur.
    task automatic fill_kernel();
        for (int i = 0; i < KERNEL_LEN; i++)
            load_entry(6'(i), $signed($urandom_range(3000)) - 1000,
                       31'($urandom_range(2000)));
    endtask

    initial begin
        logic [31:0] extremes [4];
        extremes[0] = 32'h8000_0000;
        extremes[1] = 32'h7fff_ffff;
        extremes[2] = 32'h0;
        extremes[3] = 32'hffff_ffff;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: extreme table entries, then extreme pairs at reset
        // settings, where the reach limit is zero and only coincident pairs count.
        load_entry(0, 32'sh7fff_ffff, 31'h7fff_ffff);
        load_entry(63, 32'sh8000_0000, 31'd0);
        load_entry(0, 32'sd0, 31'd0);
        // Entries read by the short pairs at a zero pixel size.
        load_entry(1, 32'sd0, 31'd0);
        load_entry(5, 32'sd0, 31'd0);
        send_item(OP_TEST, 6'd0, 0, 0, 0, 0, 32'sh7fff_ffff, 0, 0, 32'sh8000_0000);
        send_item(OP_TEST, 6'd0, 0, 0, 0, 0, 32'sh8000_0000, 0, 0, 32'sh7fff_ffff);
        send_item(OP_TEST, 6'd0, 0, 0, 5, 5, 0, 5, 5, 0);
        send_item(OP_TEST, 6'd0, 0, 0, 1, 0, 0, 0, 0, 0);
        drain();
        write_reg(REG_REACH_LIMIT, 32'h7fff_ffff);
        write_reg(REG_PIXEL_SIZE, 32'd1);
        write_reg(REG_USE_STDEV, 32'd1);
        write_reg(REG_POINT_STDEV, 32'h7fff_ffff);
        write_reg(REG_TOLERANCE, 32'h8000_0000);
        // Opposite corners of the coordinate space lie beyond the reach limit.
        send_item(OP_TEST, 0, 0, 0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                  32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
        send_item(OP_TEST, 0, 0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
                  32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff);
        send_item(OP_TEST, 0, 0, 0, 0, 0, 100, 0, 0, -100);
        drain();
        write_reg(REG_PIXEL_SIZE, 32'd0);
        write_reg(REG_TOLERANCE, 32'h7fff_ffff);
        write_reg(REG_USE_STDEV, 32'd0);
        send_item(OP_TEST, 0, 0, 0, 0, 0, 32'sh7fff_ffff, 1, 1, 32'sh8000_0000);
        send_item(OP_TEST, 0, 0, 0, 3, 4, 32'sh8000_0000, 0, 0, 32'sh7fff_ffff);
        drain();

        // Random part: several phases, each with its own settings.
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(REG_REACH_LIMIT,
                      (phase == 5) ? 32'h7fff_ffff : $urandom_range(60000));
            write_reg(REG_PIXEL_SIZE, (phase == 4) ? 32'd1 : $urandom_range(2000, 1));
            write_reg(REG_USE_STDEV, phase % 2);
            write_reg(REG_POINT_STDEV, $urandom_range(1500));
            write_reg(REG_TOLERANCE, extremes[phase % 4] & 32'h0 | ($urandom_range(2000)
                      - 1000));
            quiet_source = (phase == 2);
            quiet_sink = (phase == 2);
            fill_kernel();
            for (int n = 0; n < 92; n++) begin
                if ($urandom_range(9) == 0)
                    load_entry(6'($urandom), $urandom, 31'($urandom));
                else if ($urandom_range(9) == 0)
                    send_item(OP_TEST, 6'($urandom), $urandom, 31'($urandom), $urandom,
                              $urandom, $urandom, $urandom, $urandom, $urandom);
                else
                    test_pair((phase == 5) ? 32'h3fff_ffff : 40000);
            end
            // Full pause: the sender holds off until every verdict is back.
            drain();
        end
        quiet_source = 1'b0;
        quiet_sink = 1'b0;

        $display("Covered %0d loads and %0d pair tests (%0d in range), %0d verdicts checked.",
                 loads, tests, hits, board.checked);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("morphological_point_pair_filter_top_test passed");
        end else begin
            $display("morphological_point_pair_filter_top_test failed");
        end
        $finish;
    end
endmodule
